// ===== hw/rtl/json_string_unescape_utf8_defines.svh =====
// Assertion macros shared by the JSON unescaper checker.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and codes of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;

    localparam logic [2:0] E_QUOTE = 3'd0;
    localparam logic [2:0] E_CTRL  = 3'd1;
    localparam logic [2:0] E_ESC   = 3'd2;
    localparam logic [2:0] E_HEX   = 3'd3;
    localparam logic [2:0] E_SUR   = 3'd4;

    // One classified input byte: up to four results of the same kind.
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      code;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// Front end: escape and surrogate decoding, one byte per transfer.
`default_nettype none
module jsu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_first_of_string,
    input  wire logic          i_full,
    output logic               o_push,
    output jsu_pkg::t_job      o_job
);
    import jsu_pkg::*;

    localparam logic [3:0] M_NORMAL    = 4'd0;
    localparam logic [3:0] M_ESC       = 4'd1;
    localparam logic [3:0] M_HEX1      = 4'd2;
    localparam logic [3:0] M_HEX1_LAST = 4'd5;
    localparam logic [3:0] M_SUR_BS    = 4'd6;
    localparam logic [3:0] M_SUR_U     = 4'd7;
    localparam logic [3:0] M_HEX2      = 4'd8;
    localparam logic [3:0] M_HEX2_LAST = 4'd11;
    localparam logic [3:0] M_IGNORE    = 4'd12;

    logic [3:0]  r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_hs, n_hs;

    logic [3:0]  w_mode;
    logic [15:0] w_acc;
    logic [9:0]  w_hs;
    logic [4:0]  w_digit;
    logic [15:0] w_acc_new;
    logic [20:0] w_pair;
    logic        w_has;
    logic        w_accept;
    t_job        w_job;

    function automatic logic [4:0] hexval(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        return v;
    endfunction

    function automatic t_job encode(input logic [20:0] u);
        t_job j;
        j = '0;
        j.kind = K_DATA;
        if (u <= 21'h7F) begin
            j.bytes[0] = u[7:0];
        end else if (u <= 21'h7FF) begin
            j.last_idx = 2'd1;
            j.bytes[0] = {3'b110, u[10:6]};
            j.bytes[1] = {2'b10, u[5:0]};
        end else if (u <= 21'hFFFF) begin
            j.last_idx = 2'd2;
            j.bytes[0] = {4'b1110, u[15:12]};
            j.bytes[1] = {2'b10, u[11:6]};
            j.bytes[2] = {2'b10, u[5:0]};
        end else begin
            j.last_idx = 2'd3;
            j.bytes[0] = {5'b11110, u[20:18]};
            j.bytes[1] = {2'b10, u[17:12]};
            j.bytes[2] = {2'b10, u[11:6]};
            j.bytes[3] = {2'b10, u[5:0]};
        end
        return j;
    endfunction

    assign w_accept  = i_valid && !i_full;
    // A flagged byte restarts decoding from the reset state.
    assign w_mode    = i_first_of_string ? M_NORMAL : r_mode;
    assign w_acc     = i_first_of_string ? 16'd0 : r_acc;
    assign w_hs      = i_first_of_string ? 10'd0 : r_hs;
    assign w_digit   = hexval(i_in_byte);
    assign w_acc_new = {w_acc[11:0], w_digit[3:0]};
    assign w_pair    = {1'b0, w_hs, w_acc_new[9:0]} + 21'h10000;

    always_comb begin
        n_mode = w_mode;
        n_acc  = w_acc;
        n_hs   = w_hs;
        w_has  = 1'b0;
        w_job  = '0;
        unique case (w_mode) inside
            M_NORMAL: begin
                if (i_in_byte == 8'h22) begin
                    w_has = 1'b1;
                    w_job.kind = K_END;
                    n_mode = M_IGNORE;
                end else if (i_in_byte == 8'h00) begin
                    w_has = 1'b1;
                    w_job.kind = K_ERR;
                    w_job.code = E_QUOTE;
                    n_mode = M_IGNORE;
                end else if (i_in_byte == 8'h5C) begin
                    n_mode = M_ESC;
                end else if (i_in_byte < 8'h20) begin
                    w_has = 1'b1;
                    w_job.kind = K_ERR;
                    w_job.code = E_CTRL;
                    n_mode = M_IGNORE;
                end else begin
                    w_has = 1'b1;
                    w_job.bytes[0] = i_in_byte;
                end
            end
            M_ESC: begin
                n_mode = M_NORMAL;
                w_has  = 1'b1;
                case (i_in_byte)
                    8'h22:   w_job.bytes[0] = 8'h22;
                    8'h5C:   w_job.bytes[0] = 8'h5C;
                    8'h2F:   w_job.bytes[0] = 8'h2F;
                    8'h62:   w_job.bytes[0] = 8'h08;
                    8'h66:   w_job.bytes[0] = 8'h0C;
                    8'h6E:   w_job.bytes[0] = 8'h0A;
                    8'h74:   w_job.bytes[0] = 8'h09;
                    8'h72:   w_job.bytes[0] = 8'h0D;
                    8'h75: begin
                        w_has  = 1'b0;
                        n_acc  = 16'd0;
                        n_mode = M_HEX1;
                    end
                    default: begin
                        w_job.kind = K_ERR;
                        w_job.code = E_ESC;
                        n_mode = M_IGNORE;
                    end
                endcase
            end
            M_SUR_BS: begin
                if (i_in_byte == 8'h5C) begin
                    n_mode = M_SUR_U;
                end else begin
                    w_has = 1'b1;
                    w_job.kind = K_ERR;
                    w_job.code = E_SUR;
                    n_mode = M_IGNORE;
                end
            end
            M_SUR_U: begin
                if (i_in_byte == 8'h75) begin
                    n_acc  = 16'd0;
                    n_mode = M_HEX2;
                end else begin
                    w_has = 1'b1;
                    w_job.kind = K_ERR;
                    w_job.code = E_SUR;
                    n_mode = M_IGNORE;
                end
            end
            [M_HEX1:M_HEX1_LAST], [M_HEX2:M_HEX2_LAST]: begin
                if (w_digit[4]) begin
                    w_has = 1'b1;
                    w_job.kind = K_ERR;
                    w_job.code = E_HEX;
                    n_mode = M_IGNORE;
                end else begin
                    n_acc = w_acc_new;
                    if (w_mode == M_HEX1_LAST) begin
                        if (w_acc_new >= 16'hD800 && w_acc_new <= 16'hDBFF) begin
                            n_hs   = w_acc_new[9:0];
                            n_mode = M_SUR_BS;
                        end else begin
                            w_has  = 1'b1;
                            w_job  = encode({5'd0, w_acc_new});
                            n_mode = M_NORMAL;
                        end
                    end else if (w_mode == M_HEX2_LAST) begin
                        w_has = 1'b1;
                        if (w_acc_new < 16'hDC00 || w_acc_new > 16'hDFFF) begin
                            w_job.kind = K_ERR;
                            w_job.code = E_SUR;
                            n_mode = M_IGNORE;
                        end else begin
                            w_job  = encode(w_pair);
                            n_mode = M_NORMAL;
                        end
                    end else begin
                        n_mode = w_mode + 4'd1;
                    end
                end
            end
            default: begin
                // ignore mode and unused codes: drop the byte
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_acc  <= 16'd0;
            r_hs   <= 10'd0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_hs   <= n_hs;
        end
    end

    assign o_push = w_accept && w_has;
    assign o_job  = w_job;

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
// Short queue of classified jobs between the front and back ends.
`default_nettype none
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jsu_pkg::t_job i_job,
    input  wire logic          i_pop,
    output jsu_pkg::t_job      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import jsu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// Back end: splits queued jobs into single results behind an output register.
`default_nettype none
module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsu_pkg::t_job i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_out_byte,
    output logic [2:0]         o_error_code,
    output logic               o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_byte;
    logic [2:0] r_code;
    logic       r_last;
    logic [1:0] r_idx;
    logic       w_load;
    logic       w_end;

    // Load a new result whenever the output register is free or being taken.
    assign w_load = !i_empty && (!r_valid || !i_stall);
    assign w_end  = (r_idx == i_head.last_idx);
    assign o_pop  = w_load && w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_end ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= i_head.kind;
            r_byte <= i_head.bytes[r_idx];
            r_code <= i_head.code;
            r_last <= w_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_out_byte   = r_byte;
    assign o_error_code = r_code;
    assign o_last       = r_last;

endmodule
`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_in_byte, i_first_of_string
//   output  | out       | o_valid / i_stall  | o_kind, o_out_byte, o_error_code, o_last
//
// One input byte is taken per cycle while the job queue has room; its results
// leave at one per cycle while i_stall is low, so a \u escape that yields n UTF-8
// bytes leaves as n results in turn. The QUEUE_DEPTH-entry job queue absorbs that.
// Reset is synchronous, active low; it clears the decode mode, the queue and
// the output valid. Output stalls back up into the queue, then into o_stall.
`default_nettype none
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_first_of_string,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_error_code,
    output logic            o_last
);
    import jsu_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_job w_job;
    t_job w_head;

    assign o_stall = w_full;

    jsu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_in_byte         (i_in_byte),
        .i_first_of_string (i_first_of_string),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_job             (w_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_checker.sv =====
// Port-level checker for the JSON string unescaper, with its bind.
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_out_byte,
    input wire logic [2:0] o_error_code,
    input wire logic       o_last
);
    import jsu_pkg::*;

    logic        w_held;
    logic [10:0] w_hold_bits;
    logic        w_end_err;
    logic        w_is_data;
    logic        w_is_end;
    logic        w_kind_ok;

    assign w_held      = o_valid && i_stall;
    assign w_hold_bits = {o_kind, o_out_byte, o_last};
    assign w_end_err   = o_valid && (o_kind == K_END || o_kind == K_ERR);
    assign w_is_data   = o_valid && o_kind == K_DATA;
    assign w_is_end    = o_valid && o_kind == K_END;
    assign w_kind_ok   = (o_kind == K_DATA || o_kind == K_END || o_kind == K_ERR);

    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_valid && $stable(w_hold_bits))
    `JSU_ASSERT_IMPL(a_end_err_last, i_clk, i_rst_n, w_end_err, o_last && o_out_byte == 8'd0)
    `JSU_ASSERT_IMPL(a_data_no_code, i_clk, i_rst_n, w_is_data, o_error_code == E_QUOTE)
    `JSU_ASSERT_IMPL(a_kind_legal, i_clk, i_rst_n, o_valid, w_kind_ok)
    `JSU_ASSERT_IMPL(a_end_no_code, i_clk, i_rst_n, w_is_end, o_error_code == E_QUOTE)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_out_byte   (o_out_byte),
    .o_error_code (o_error_code),
    .o_last       (o_last)
);
`default_nettype wire
